// ----- sv/cfq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants of the circular fifo queue core.
// ----------------------------------------------------------------------------
package cfq_pkg;

  // default build sizes
  localparam int unsigned CfqDepth     = 1024;
  localparam int unsigned CfqDataWidth = 16;

  // operation code carried by a request beat
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_READ,
    ST_LOAD
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic read;
    logic load;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic rsp_stall;
  } status_t;

endpackage

// ----- sv/cfq_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_req_if
// Request channel: one enqueue or dequeue per beat.
// ----------------------------------------------------------------------------
interface cfq_req_if
  import cfq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = CfqDataWidth
);
  logic                  valid;
  logic                  ready;
  cmd_e                  cmd;
  logic [DATA_WIDTH-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ----- sv/cfq_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_rsp_if
// Response channel: status and front/rear words after each operation.
// ----------------------------------------------------------------------------
interface cfq_rsp_if
  import cfq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = CfqDataWidth,
  parameter int unsigned CNT_W      = $clog2(CfqDepth + 1)
);
  logic                  valid;
  logic                  ready;
  logic                  accepted;
  logic                  is_empty;
  logic                  is_full;
  logic [CNT_W-1:0]      occupancy;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] rear_value;

  modport source (output valid, output accepted, output is_empty, output is_full,
                  output occupancy, output front_value, output rear_value,
                  input ready);
  modport sink   (input valid, input accepted, input is_empty, input is_full,
                  input occupancy, input front_value, input rear_value,
                  output ready);
endinterface

// ----- sv/circular_fifo_queue_core.sv -----
`timescale 1ns / 1ps
// Sequence: capture, pointer update, memory read and response load, in order;
//   the response beat is valid once loaded, and the load waits while the last
//   response is held. No new request is taken until that load is done.
// Reset: pointers and occupancy clear, capacity returns to the built depth;
//   the entry memory is not cleared.
// ----------------------------------------------------------------------------
// circular_fifo_queue_core
// Ring-buffer fifo with a programmable capacity, one response per request.
// ----------------------------------------------------------------------------
module circular_fifo_queue_core
  import cfq_pkg::*;
#(
  parameter int unsigned DEPTH      = CfqDepth,
  parameter int unsigned DATA_WIDTH = CfqDataWidth,
  parameter int unsigned CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  cfq_req_if.sink          req_i,
  cfq_rsp_if.source        rsp_o
);

  ctrl_t   ctrl;
  status_t status;

  // sequencer
  cfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // storage and pointers
  cfq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .req_cmd_i         (req_i.cmd),
    .req_value_i       (req_i.value),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_accepted_o    (rsp_o.accepted),
    .rsp_is_empty_o    (rsp_o.is_empty),
    .rsp_is_full_o     (rsp_o.is_full),
    .rsp_occupancy_o   (rsp_o.occupancy),
    .rsp_front_value_o (rsp_o.front_value),
    .rsp_rear_value_o  (rsp_o.rear_value),
    .ctrl_i            (ctrl),
    .status_o          (status)
  );

endmodule

// ----- sv/cfq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_ctrl
// Sequencer: capture, pointer update, memory read, response load.
// ----------------------------------------------------------------------------
module cfq_ctrl
  import cfq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_READ;
      ST_READ:   state_d = ST_LOAD;
      ST_LOAD: begin
        if (!status_i.rsp_stall) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o = 1'b0;
    ctrl_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o    = 1'b1;
        ctrl_o.capture = req_valid_i;
      end
      ST_UPDATE: ctrl_o.update = 1'b1;
      ST_READ:   ctrl_o.read   = 1'b1;
      ST_LOAD:   ctrl_o.load   = !status_i.rsp_stall;
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/cfq_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_dpath
// Entry memory, ring pointers, occupancy count and response register.
// ----------------------------------------------------------------------------
module cfq_dpath
  import cfq_pkg::*;
#(
  parameter int unsigned DEPTH      = CfqDepth,
  parameter int unsigned DATA_WIDTH = CfqDataWidth,
  parameter int unsigned CNT_W      = $clog2(DEPTH + 1),
  parameter int unsigned PTR_W      = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_data_i,
  input  cmd_e                  req_cmd_i,
  input  logic [DATA_WIDTH-1:0] req_value_i,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output logic                  rsp_accepted_o,
  output logic                  rsp_is_empty_o,
  output logic                  rsp_is_full_o,
  output logic [CNT_W-1:0]      rsp_occupancy_o,
  output logic [DATA_WIDTH-1:0] rsp_front_value_o,
  output logic [DATA_WIDTH-1:0] rsp_rear_value_o,
  input  ctrl_t                 ctrl_i,
  output status_t               status_o
);

  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CntMax  = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];

  logic [CNT_W-1:0]      cap_q;
  cmd_e                  cmd_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [PTR_W-1:0]      head_q, tail_q;
  logic [CNT_W-1:0]      count_q;
  logic                  ok_q;
  logic [DATA_WIDTH-1:0] front_rd_q, rear_rd_q;

  logic                  rsp_valid_q;
  logic                  rsp_accepted_q, rsp_is_empty_q, rsp_is_full_q;
  logic [CNT_W-1:0]      rsp_occupancy_q;
  logic [DATA_WIDTH-1:0] rsp_front_q, rsp_rear_q;

  logic [CNT_W-1:0]      eff_cap;
  logic [PTR_W-1:0]      head_next, tail_next, rear_pos;
  logic                  do_enq, do_deq, empty;

  // effective capacity saturates at the built depth
  assign eff_cap   = (cap_q > CntMax) ? CntMax : cap_q;

  // ring pointer arithmetic
  assign head_next = (head_q == PtrLast) ? '0 : head_q + PTR_W'(1);
  assign tail_next = (tail_q == PtrLast) ? '0 : tail_q + PTR_W'(1);
  assign rear_pos  = (tail_q == '0) ? PtrLast : tail_q - PTR_W'(1);

  assign do_enq = (cmd_q == CMD_ENQ) && (count_q < eff_cap);
  assign do_deq = (cmd_q == CMD_DEQ) && (count_q != '0);
  assign empty  = (count_q == '0);

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CntMax;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= req_cmd_i;
      value_q <= req_value_i;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
    end else if (ctrl_i.update) begin
      ok_q <= do_enq || do_deq;
      if (do_enq) begin
        tail_q  <= tail_next;
        count_q <= count_q + CNT_W'(1);
      end else if (do_deq) begin
        head_q  <= head_next;
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // entry memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ctrl_i.update && do_enq) begin
      mem_q[tail_q] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.read) begin
      front_rd_q <= mem_q[head_q];
      rear_rd_q  <= mem_q[rear_pos];
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rsp_accepted_q  <= ok_q;
      rsp_is_empty_q  <= empty;
      rsp_is_full_q   <= (count_q >= eff_cap);
      rsp_occupancy_q <= count_q;
      rsp_front_q     <= empty ? '0 : front_rd_q;
      rsp_rear_q      <= empty ? '0 : rear_rd_q;
    end
  end

  assign status_o.rsp_stall = rsp_valid_q && !rsp_ready_i;

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_accepted_o    = rsp_accepted_q;
  assign rsp_is_empty_o    = rsp_is_empty_q;
  assign rsp_is_full_o     = rsp_is_full_q;
  assign rsp_occupancy_o   = rsp_occupancy_q;
  assign rsp_front_value_o = rsp_front_q;
  assign rsp_rear_value_o  = rsp_rear_q;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of circular_fifo_queue_core. A shadow fifo in the bench predicts
// the status beat of every enqueue and dequeue it sends. A checker takes
// response beats under random stalls and compares every field in order.
// Covers refused operations, programmed capacities from zero up past the
// depth, capacity cut below occupancy, and a fill to full depth across the
// ring wrap.
// ----------------------------------------------------------------------------
module tb;
  import cfq_pkg::*;

  localparam int unsigned CntW = $clog2(CfqDepth + 1);
  localparam logic [CntW-1:0] CapMax = '1;

  typedef logic [CfqDataWidth-1:0] word_t;

  // status carried by one response beat
  typedef struct packed {
    logic            accepted;
    logic            is_empty;
    logic            is_full;
    logic [CntW-1:0] occupancy;
    word_t           front_value;
    word_t           rear_value;
  } fifo_status_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_data_i;

  cfq_req_if req_if ();
  cfq_rsp_if rsp_if ();

  circular_fifo_queue_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow fifo state
  word_t        shadow_mem [CfqDepth];
  int unsigned  rd_ptr;
  int unsigned  wr_ptr;
  int unsigned  fill_level;
  int unsigned  cap_setting;
  fifo_status_t pending_status [$];
  int unsigned  err_count;
  bit           src_idle_en;
  bit           snk_stall_en;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // apply one operation to the shadow fifo, return the status it reports
  function automatic fifo_status_t apply_fifo_op(cmd_e op, word_t word);
    fifo_status_t st;
    int unsigned  limit;
    int unsigned  last;
    limit = (cap_setting > CfqDepth) ? CfqDepth : cap_setting;
    st = '0;
    if (op == CMD_ENQ) begin
      if (fill_level < limit) begin
        shadow_mem[wr_ptr] = word;
        wr_ptr = (wr_ptr + 1) % CfqDepth;
        fill_level++;
        st.accepted = 1'b1;
      end
    end else if (fill_level > 0) begin
      rd_ptr = (rd_ptr + 1) % CfqDepth;
      fill_level--;
      st.accepted = 1'b1;
    end
    last = (wr_ptr == 0) ? CfqDepth - 1 : wr_ptr - 1;
    st.is_empty  = (fill_level == 0);
    st.is_full   = (fill_level >= limit);
    st.occupancy = CntW'(fill_level);
    if (fill_level > 0) begin
      st.front_value = shadow_mem[rd_ptr];
      st.rear_value  = shadow_mem[last];
    end
    return st;
  endfunction

  // send one request beat, record the predicted status once it is taken
  task automatic send_op(cmd_e op, word_t word);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= op;
    req_if.value <= word;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_status.push_back(apply_fifo_op(op, word));
  endtask

  // stop sending and wait for every outstanding response
  task automatic settle_idle();
    req_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // program the capacity register, block must be idle
  task automatic set_capacity(logic [CntW-1:0] cap);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_setting = cap;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  // response checker
  initial begin
    int unsigned  stall;
    fifo_status_t want;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = snk_stall_en ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      if (pending_status.size() == 0) begin
        $error("response beat with no operation outstanding");
        err_count++;
      end else begin
        want = pending_status.pop_front();
        compare_field("accepted", want.accepted, rsp_if.accepted);
        compare_field("is_empty", want.is_empty, rsp_if.is_empty);
        compare_field("is_full", want.is_full, rsp_if.is_full);
        compare_field("occupancy", want.occupancy, rsp_if.occupancy);
        compare_field("front_value", want.front_value, rsp_if.front_value);
        compare_field("rear_value", want.rear_value, rsp_if.rear_value);
      end
    end
  end

  // empty queue at reset, extreme words, dequeue from empty
  task automatic test_basic_ops();
    src_idle_en  = 1'b1;
    snk_stall_en = 1'b1;
    send_op(CMD_DEQ, 16'h1234);
    send_op(CMD_ENQ, 16'h0000);
    send_op(CMD_ENQ, 16'hFFFF);
    send_op(CMD_ENQ, 16'h5A5A);
    send_op(CMD_DEQ, 16'hFFFF);
    send_op(CMD_DEQ, 16'h0000);
    send_op(CMD_DEQ, 16'hA5A5);
    send_op(CMD_DEQ, 16'h0001);
  endtask

  // single entry queue: full after one enqueue
  task automatic test_capacity_one();
    settle_idle();
    set_capacity(CntW'(1));
    send_op(CMD_ENQ, 16'hFFFF);
    send_op(CMD_ENQ, 16'h0001);
    send_op(CMD_DEQ, 16'h0000);
    send_op(CMD_DEQ, 16'h0000);
  endtask

  // capacity cut below occupancy, then to zero while entries are held
  task automatic test_capacity_shrink();
    settle_idle();
    set_capacity(CntW'(3));
    send_op(CMD_ENQ, 16'hA5A5);
    send_op(CMD_ENQ, 16'h8000);
    send_op(CMD_ENQ, 16'h0001);
    settle_idle();
    set_capacity(CntW'(1));
    send_op(CMD_ENQ, 16'h7FFF);
    send_op(CMD_DEQ, 16'h0000);
    send_op(CMD_DEQ, 16'h0000);
    send_op(CMD_ENQ, 16'h1111);
    settle_idle();
    set_capacity('0);
    send_op(CMD_ENQ, 16'h2222);
    send_op(CMD_DEQ, 16'h0000);
    send_op(CMD_DEQ, 16'h0000);
    send_op(CMD_ENQ, 16'hFFFF);
  endtask

  // random phases over a spread of capacities and enqueue mixes
  task automatic test_random_mix();
    logic [CntW-1:0] caps [12];
    int unsigned     enq_pct;
    caps = '{CntW'(1), CntW'(2), '0, CntW'(4), CntW'(1025), CntW'(16),
             CntW'(3), CapMax, CntW'(8), CntW'(1024), CntW'(5), CntW'(2)};
    foreach (caps[p]) begin
      settle_idle();
      set_capacity(caps[p]);
      src_idle_en  = ($urandom_range(0, 3) != 0);
      snk_stall_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       enq_pct = 30;
        1:       enq_pct = 50;
        default: enq_pct = 70;
      endcase
      repeat (35) begin
        send_op(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ, word_t'($urandom));
      end
    end
  endtask

  // fill to the full depth with the capacity saturated, crossing the ring wrap
  task automatic test_fill_to_depth();
    settle_idle();
    set_capacity(CapMax);
    src_idle_en  = ($urandom_range(0, 1) != 0);
    snk_stall_en = ($urandom_range(0, 1) != 0);
    while (fill_level < CfqDepth) begin
      send_op(CMD_ENQ, word_t'($urandom));
    end
    send_op(CMD_ENQ, word_t'($urandom));
    src_idle_en  = 1'b1;
    snk_stall_en = 1'b1;
    // toggle around the full boundary
    repeat (10) begin
      send_op(CMD_DEQ, word_t'($urandom));
      send_op(CMD_ENQ, word_t'($urandom));
    end
    settle_idle();
    set_capacity(CntW'(1));
    send_op(CMD_ENQ, word_t'($urandom));
    send_op(CMD_DEQ, word_t'($urandom));
  endtask

  // sequence
  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_data_i   <= '0;
    req_if.valid <= 1'b0;
    req_if.cmd   <= CMD_ENQ;
    req_if.value <= '0;
    rd_ptr       = 0;
    wr_ptr       = 0;
    fill_level   = 0;
    cap_setting  = CfqDepth;
    err_count    = 0;
    src_idle_en  = 1'b1;
    snk_stall_en = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_capacity_one();
    test_capacity_shrink();
    test_random_mix();
    test_fill_to_depth();

    settle_idle();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
